// ===== hw/rtl/piecewise_linear_interpolator_top_defines.svh =====
// Assertion macros shared by the interpolator RTL.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PWLI_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pwli: property violated");
`define PWLI_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("pwli: forbidden condition");
`else
`define PWLI_ASSERT(lbl, clk, rstn, prop)
`define PWLI_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== hw/rtl/pwli_pkg.sv =====
// Shared types and constants of the piecewise linear interpolator.
package pwli_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned FREQ_BITS_DEF  = 24;
  localparam int unsigned AMPL_BITS_DEF  = 24;
  localparam int unsigned IDX_IN_W       = 6;
  localparam int unsigned NPTS_W         = 7;
  localparam int unsigned FIFO_DEPTH     = 2;
  localparam int unsigned CMD_W_DEF      = 1 + IDX_IN_W + FREQ_BITS_DEF + AMPL_BITS_DEF;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/pwli_front.sv =====
// Front end: accepts items, drops loads to missing slots, forms queue commands.
module pwli_front #(
  parameter int unsigned MAX_POINTS = pwli_pkg::MAX_POINTS_DEF,
  parameter int unsigned FREQ_BITS  = pwli_pkg::FREQ_BITS_DEF,
  parameter int unsigned AMPL_BITS  = pwli_pkg::AMPL_BITS_DEF,
  parameter int unsigned CMD_W      = 1 + pwli_pkg::IDX_IN_W + FREQ_BITS + AMPL_BITS
) (
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [pwli_pkg::IDX_IN_W-1:0] point_index_i,
  input  logic [FREQ_BITS-1:0]          point_freq_i,
  input  logic signed [AMPL_BITS-1:0]   point_ampl_i,
  input  logic [FREQ_BITS-1:0]          query_freq_i,
  input  pwli_pkg::fifo_stat_t          stat_i,
  output logic                          push_o,
  output logic [CMD_W-1:0]              cmd_o
);

  logic                 is_query;
  logic                 idx_ok;
  logic [FREQ_BITS-1:0] freq_sel;

  assign is_query = (pwli_pkg::op_e'(req_type_i) == pwli_pkg::OP_QUERY);
  assign idx_ok   = (32'(point_index_i) < 32'(MAX_POINTS));
  assign freq_sel = is_query ? query_freq_i : point_freq_i;

  assign busy   = stat_i.full;
  assign push_o = start && !stat_i.full && (is_query || idx_ok);
  assign cmd_o  = {req_type_i, point_index_i, freq_sel, point_ampl_i};

endmodule

// ===== hw/rtl/pwli_fifo.sv =====
// Short command queue between the front end and the back end.
`include "piecewise_linear_interpolator_top_defines.svh"

module pwli_fifo #(
  parameter int unsigned WIDTH = pwli_pkg::CMD_W_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [WIDTH-1:0]     data_i,
  input  logic                 pop_i,
  output logic [WIDTH-1:0]     data_o,
  output pwli_pkg::fifo_stat_t stat_o
);

  localparam int unsigned DEPTH = pwli_pkg::FIFO_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign data_o       = slot_q[rptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  `PWLI_NEVER(a_fifo_overflow, clk_i, rst_ni, push_i && stat_o.full)
  `PWLI_NEVER(a_fifo_underflow, clk_i, rst_ni, pop_i && stat_o.empty)
  `PWLI_ASSERT(a_fifo_ptrs, clk_i, rst_ni, (cnt_q == '0) |-> (wptr_q == rptr_q))

endmodule

// ===== hw/rtl/pwli_back.sv =====
// Back end: breakpoint memory, segment scan, serial divider and result register.
`include "piecewise_linear_interpolator_top_defines.svh"

module pwli_back #(
  parameter int unsigned MAX_POINTS = pwli_pkg::MAX_POINTS_DEF,
  parameter int unsigned FREQ_BITS  = pwli_pkg::FREQ_BITS_DEF,
  parameter int unsigned AMPL_BITS  = pwli_pkg::AMPL_BITS_DEF,
  parameter int unsigned CMD_W      = 1 + pwli_pkg::IDX_IN_W + FREQ_BITS + AMPL_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pwli_pkg::NPTS_W-1:0] num_points_i,
  input  logic [CMD_W-1:0]            cmd_i,
  input  pwli_pkg::fifo_stat_t        stat_i,
  output logic                        pop_o,
  output logic                        valid_o,
  output logic signed [AMPL_BITS-1:0] amplitude_o,
  output logic                        in_range_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int unsigned DCNT_W = $clog2(AMPL_BITS);
  localparam int unsigned ENT_W  = FREQ_BITS + AMPL_BITS;
  localparam int unsigned PROD_W = FREQ_BITS + AMPL_BITS;

  // command fields
  logic                          cmd_op;
  logic [pwli_pkg::IDX_IN_W-1:0] cmd_idx;
  logic [FREQ_BITS-1:0]          cmd_freq;
  logic [AMPL_BITS-1:0]          cmd_ampl;

  assign cmd_op   = cmd_i[CMD_W-1];
  assign cmd_idx  = cmd_i[CMD_W-2 -: pwli_pkg::IDX_IN_W];
  assign cmd_freq = cmd_i[ENT_W-1:AMPL_BITS];
  assign cmd_ampl = cmd_i[AMPL_BITS-1:0];

  // breakpoint memory
  logic [ENT_W-1:0] mem [MAX_POINTS];
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data_q;
  logic [FREQ_BITS-1:0] cur_f;
  logic [AMPL_BITS-1:0] cur_a;

  assign wr_addr = IDX_W'(cmd_idx);
  assign cur_f   = rd_data_q[ENT_W-1:AMPL_BITS];
  assign cur_a   = rd_data_q[AMPL_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= {cmd_freq, cmd_ampl};
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // state
  pwli_pkg::back_state_e state_q, state_d;
  logic [CNT_W-1:0]      n_q, n_d, n_cfg;
  logic [CNT_W-1:0]      ic_q, ic_d;
  logic                  dv_q, dv_d;
  logic                  first_q, first_d;
  logic                  found_q, found_d;
  logic [DCNT_W-1:0]     dcnt_q, dcnt_d;
  logic                  res_vld_q, res_vld_d;

  logic [FREQ_BITS-1:0]  q_q, q_d;
  logic [FREQ_BITS-1:0]  prev_f_q, prev_f_d;
  logic [AMPL_BITS-1:0]  prev_a_q, prev_a_d;
  logic [FREQ_BITS-1:0]  ffirst_q, ffirst_d;
  logic [FREQ_BITS-1:0]  s_f0_q, s_f0_d, s_f1_q, s_f1_d;
  logic [AMPL_BITS-1:0]  s_a0_q, s_a0_d, s_a1_q, s_a1_d;
  logic [FREQ_BITS-1:0]  t_q, t_d, dx_q, dx_d;
  logic [AMPL_BITS-1:0]  mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic [FREQ_BITS-1:0]  rem_q, rem_d;
  logic [AMPL_BITS-1:0]  lo_q, lo_d;
  logic [AMPL_BITS-1:0]  res_amp_q, res_amp_d;
  logic                  res_rng_q, res_rng_d;

  logic                  in_rng;
  logic signed [AMPL_BITS:0] dy;
  logic [AMPL_BITS:0]    dy_abs;
  logic [PROD_W-1:0]     prod;
  logic [FREQ_BITS:0]    trial;
  logic [FREQ_BITS:0]    diff;
  logic                  ge;

  always_comb begin
    if (32'(num_points_i) > 32'(MAX_POINTS)) begin
      n_cfg = CNT_W'(MAX_POINTS);
    end else begin
      n_cfg = CNT_W'(num_points_i);
    end
  end

  assign in_rng = (n_q >= CNT_W'(2)) && (q_q >= ffirst_q) && (q_q <= prev_f_q);
  assign dy     = $signed({s_a1_q[AMPL_BITS-1], s_a1_q})
                - $signed({s_a0_q[AMPL_BITS-1], s_a0_q});
  assign dy_abs = dy[AMPL_BITS] ? (AMPL_BITS+1)'(-dy) : (AMPL_BITS+1)'(dy);
  assign prod   = mag_q * t_q;
  assign trial  = {rem_q, lo_q[AMPL_BITS-1]};
  assign diff   = trial - {1'b0, dx_q};
  assign ge     = (trial >= {1'b0, dx_q});

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    ic_d      = ic_q;
    dv_d      = dv_q;
    first_d   = first_q;
    found_d   = found_q;
    dcnt_d    = dcnt_q;
    res_vld_d = 1'b0;
    q_d       = q_q;
    prev_f_d  = prev_f_q;
    prev_a_d  = prev_a_q;
    ffirst_d  = ffirst_q;
    s_f0_d    = s_f0_q;
    s_f1_d    = s_f1_q;
    s_a0_d    = s_a0_q;
    s_a1_d    = s_a1_q;
    t_d       = t_q;
    dx_d      = dx_q;
    mag_d     = mag_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    lo_d      = lo_q;
    res_amp_d = res_amp_q;
    res_rng_d = res_rng_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = ic_q[IDX_W-1:0];
    case (state_q)
      pwli_pkg::ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o = 1'b1;
          if (pwli_pkg::op_e'(cmd_op) == pwli_pkg::OP_LOAD) begin
            mem_we = 1'b1;
          end else begin
            q_d     = cmd_freq;
            n_d     = n_cfg;
            ic_d    = '0;
            dv_d    = 1'b0;
            first_d = 1'b1;
            found_d = 1'b0;
            state_d = pwli_pkg::ST_SCAN;
          end
        end
      end
      pwli_pkg::ST_SCAN: begin
        if (ic_q < n_q) begin
          rd_en = 1'b1;
          ic_d  = ic_q + CNT_W'(1);
          dv_d  = 1'b1;
        end else begin
          dv_d = 1'b0;
          if (!dv_q) begin
            state_d = pwli_pkg::ST_EVAL;
          end
        end
        if (dv_q) begin
          if (first_q) begin
            ffirst_d = cur_f;
          end else if ((prev_f_q <= q_q) && (q_q <= cur_f)) begin
            found_d = 1'b1;
            s_f0_d  = prev_f_q;
            s_a0_d  = prev_a_q;
            s_f1_d  = cur_f;
            s_a1_d  = cur_a;
          end
          prev_f_d = cur_f;
          prev_a_d = cur_a;
          first_d  = 1'b0;
        end
      end
      pwli_pkg::ST_EVAL: begin
        res_rng_d = in_rng;
        neg_d     = dy[AMPL_BITS];
        mag_d     = dy_abs[AMPL_BITS-1:0];
        t_d       = q_q - s_f0_q;
        dx_d      = s_f1_q - s_f0_q;
        if (!in_rng || !found_q) begin
          res_amp_d = '0;
          res_vld_d = 1'b1;
          state_d   = pwli_pkg::ST_IDLE;
        end else if (s_f0_q == s_f1_q) begin
          res_amp_d = s_a1_q;
          res_vld_d = 1'b1;
          state_d   = pwli_pkg::ST_IDLE;
        end else begin
          state_d = pwli_pkg::ST_MUL;
        end
      end
      pwli_pkg::ST_MUL: begin
        // high part is below dx since the quotient fits the amplitude width
        rem_d   = prod[PROD_W-1:AMPL_BITS];
        lo_d    = prod[AMPL_BITS-1:0];
        dcnt_d  = '0;
        state_d = pwli_pkg::ST_DIV;
      end
      pwli_pkg::ST_DIV: begin
        rem_d  = ge ? diff[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];
        lo_d   = {lo_q[AMPL_BITS-2:0], ge};
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(AMPL_BITS - 1)) begin
          state_d = pwli_pkg::ST_FIN;
        end
      end
      pwli_pkg::ST_FIN: begin
        res_amp_d = neg_q ? (s_a0_q - lo_q) : (s_a0_q + lo_q);
        res_vld_d = 1'b1;
        state_d   = pwli_pkg::ST_IDLE;
      end
      default: begin
        state_d = pwli_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pwli_pkg::ST_IDLE;
      n_q       <= '0;
      ic_q      <= '0;
      dv_q      <= 1'b0;
      first_q   <= 1'b0;
      found_q   <= 1'b0;
      dcnt_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      n_q       <= n_d;
      ic_q      <= ic_d;
      dv_q      <= dv_d;
      first_q   <= first_d;
      found_q   <= found_d;
      dcnt_q    <= dcnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q       <= q_d;
    prev_f_q  <= prev_f_d;
    prev_a_q  <= prev_a_d;
    ffirst_q  <= ffirst_d;
    s_f0_q    <= s_f0_d;
    s_f1_q    <= s_f1_d;
    s_a0_q    <= s_a0_d;
    s_a1_q    <= s_a1_d;
    t_q       <= t_d;
    dx_q      <= dx_d;
    mag_q     <= mag_d;
    neg_q     <= neg_d;
    rem_q     <= rem_d;
    lo_q      <= lo_d;
    res_amp_q <= res_amp_d;
    res_rng_q <= res_rng_d;
  end

  assign valid_o     = res_vld_q;
  assign amplitude_o = res_amp_q;
  assign in_range_o  = res_rng_q;

  `PWLI_ASSERT(a_single_strobe, clk_i, rst_ni, res_vld_q |=> !res_vld_q)
  `PWLI_ASSERT(a_out_of_range_zero, clk_i, rst_ni, (res_vld_q && !res_rng_q) |-> (res_amp_q == '0))
  `PWLI_ASSERT(a_scan_bound, clk_i, rst_ni, (state_q == pwli_pkg::ST_SCAN) |-> (ic_q <= n_q))

endmodule

// ===== hw/rtl/piecewise_linear_interpolator_top.sv =====
// Top level of the piecewise linear interpolator.
//
//  channel   direction  handshake               payload
//  item      in         start high, busy low    req_type_i, point_index_i, point_freq_i,
//                                               point_ampl_i, query_freq_i
//  result    out        valid_o one-cycle pulse amplitude_o, in_range_o
//  config    in         num_points_we_i         num_points_i
//
// A load is written to the breakpoint memory when the back end pops it; a query
// runs the one-entry-per-cycle table scan over n, the clamped point count, and,
// when it must divide, the one-bit-per-cycle divider. Items wait in a two-entry
// queue; busy is high while it is full. rst_ni clears control state; the tables
// hold nothing until loaded. Results cannot be held off by the receiver.
module piecewise_linear_interpolator_top #(
  parameter int unsigned MAX_POINTS = pwli_pkg::MAX_POINTS_DEF,
  parameter int unsigned FREQ_BITS  = pwli_pkg::FREQ_BITS_DEF,
  parameter int unsigned AMPL_BITS  = pwli_pkg::AMPL_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type_i,
  input  logic [pwli_pkg::IDX_IN_W-1:0] point_index_i,
  input  logic [FREQ_BITS-1:0]          point_freq_i,
  input  logic signed [AMPL_BITS-1:0]   point_ampl_i,
  input  logic [FREQ_BITS-1:0]          query_freq_i,
  input  logic                          num_points_we_i,
  input  logic [pwli_pkg::NPTS_W-1:0]   num_points_i,
  output logic                          valid_o,
  output logic signed [AMPL_BITS-1:0]   amplitude_o,
  output logic                          in_range_o
);

  localparam int unsigned CMD_W = 1 + pwli_pkg::IDX_IN_W + FREQ_BITS + AMPL_BITS;

  logic [pwli_pkg::NPTS_W-1:0] num_points_q, num_points_d;
  pwli_pkg::fifo_stat_t        stat;
  logic                        push;
  logic                        pop;
  logic [CMD_W-1:0]            cmd_in;
  logic [CMD_W-1:0]            cmd_out;

  assign num_points_d = num_points_we_i ? num_points_i : num_points_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= '0;
    end else begin
      num_points_q <= num_points_d;
    end
  end

  pwli_front #(
    .MAX_POINTS (MAX_POINTS),
    .FREQ_BITS  (FREQ_BITS),
    .AMPL_BITS  (AMPL_BITS),
    .CMD_W      (CMD_W)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .point_index_i (point_index_i),
    .point_freq_i  (point_freq_i),
    .point_ampl_i  (point_ampl_i),
    .query_freq_i  (query_freq_i),
    .stat_i        (stat),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  pwli_fifo #(
    .WIDTH (CMD_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .pop_i  (pop),
    .data_o (cmd_out),
    .stat_o (stat)
  );

  pwli_back #(
    .MAX_POINTS (MAX_POINTS),
    .FREQ_BITS  (FREQ_BITS),
    .AMPL_BITS  (AMPL_BITS),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_points_i (num_points_q),
    .cmd_i        (cmd_out),
    .stat_i       (stat),
    .pop_o        (pop),
    .valid_o      (valid_o),
    .amplitude_o  (amplitude_o),
    .in_range_o   (in_range_o)
  );

endmodule
